[rtl/sgi_pkg.sv]
// Shared constants, types and helpers for the 2D segment intersection block.
// No dependencies; used by every module under rtl.
package sgi_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned TFracBits = 16;
  // Differences carry one extra bit, products twice that, area sums two more.
  localparam int unsigned DiffBits  = CoordBits + 1;
  localparam int unsigned ProdBits  = 2 * DiffBits;
  localparam int unsigned AreaBits  = ProdBits + 2;
  // Magnitudes of the crossing areas and their sum.
  localparam int unsigned MagBits   = AreaBits;
  localparam int unsigned DenBits   = AreaBits + 1;
  // Remainder of the restoring division, one bit wider than the divisor.
  localparam int unsigned RemBits   = DenBits + 1;
  localparam int unsigned InBits    = 8 * CoordBits;
  localparam int unsigned OutBits   = ((1 + TFracBits + 2 * CoordBits + 7) / 8) * 8;

  typedef logic signed [CoordBits-1:0] coord_t;
  typedef logic signed [AreaBits-1:0]  area_t;

  // Item moving down the divider row: quotient bits so far and the context
  // needed at the end to form the crossing point.
  typedef struct packed {
    logic                  hit;
    logic [RemBits-1:0]    rem;
    logic [DenBits-1:0]    den;
    logic [TFracBits-1:0]  quo;
    coord_t                a_x;
    coord_t                a_y;
    logic signed [DiffBits-1:0] span_x;
    logic signed [DiffBits-1:0] span_y;
  } sgi_cell_t;

endpackage

[rtl/sgi_div_cell.sv]
// One restoring-division cell: produces one quotient bit of t per item.
// Depends on sgi_pkg.
module sgi_div_cell
  import sgi_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  logic      vld_i,
  input  sgi_cell_t cell_i,
  output logic      vld_o,
  output sgi_cell_t cell_o
);

  logic                vld_q;
  sgi_cell_t           cell_q, cell_d;
  logic [RemBits-1:0]  trial;

  // Shifted remainder was formed upstream; compare, subtract, shift on.
  always_comb begin
    cell_d = cell_i;
    trial  = cell_i.rem - RemBits'(cell_i.den);
    if (cell_i.rem >= RemBits'(cell_i.den)) begin
      cell_d.rem = {trial[RemBits-2:0], 1'b0};
      cell_d.quo = {cell_i.quo[TFracBits-2:0], 1'b1};
    end else begin
      cell_d.rem = {cell_i.rem[RemBits-2:0], 1'b0};
      cell_d.quo = {cell_i.quo[TFracBits-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (en_i) begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      cell_q <= cell_d;
    end
  end

  assign vld_o  = vld_q;
  assign cell_o = cell_q;

endmodule

[rtl/segment_intersect_2d.sv]
// Top level of the 2D segment intersection block.
// Path from input beat to output beat: stages 1 to 5, the division cells, then stages A and B.
// Throughput: one item per cycle; the pipeline stalls as a whole on tready.
// The row of TFracBits division cells is the longest part of the pipeline.
// Reset clears all valid flags; payload registers are not reset.
// Depends on sgi_pkg and sgi_div_cell.
module segment_intersect_2d
  import sgi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y from the lowest bit up
  input  logic [InBits-1:0]  s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // hit, param_t, point_x, point_y from the lowest bit up, zero filled
  output logic [OutBits-1:0] m_axis_tdata
);

  localparam int unsigned NCell = TFracBits;
  localparam int unsigned DBits = DiffBits;

  logic en;
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  coord_t ax, ay, bx, by, cx, cy, dx, dy;
  assign {dy, dx, cy, cx, by, bx, ay, ax} = s_axis_tdata;

  // Stage 1: coordinate differences.
  logic v1_q;
  logic signed [DBits-1:0] adx_q, ady_q, bdx_q, bdy_q, acx_q, acy_q, bcx_q, bcy_q;
  logic signed [DBits-1:0] cax_q, cay_q, dax_q, day_q, sx1_q, sy1_q;
  coord_t ax1_q, ay1_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      adx_q <= DBits'(ax) - DBits'(dx); ady_q <= DBits'(ay) - DBits'(dy);
      bdx_q <= DBits'(bx) - DBits'(dx); bdy_q <= DBits'(by) - DBits'(dy);
      acx_q <= DBits'(ax) - DBits'(cx); acy_q <= DBits'(ay) - DBits'(cy);
      bcx_q <= DBits'(bx) - DBits'(cx); bcy_q <= DBits'(by) - DBits'(cy);
      cax_q <= DBits'(cx) - DBits'(ax); cay_q <= DBits'(cy) - DBits'(ay);
      dax_q <= DBits'(dx) - DBits'(ax); day_q <= DBits'(dy) - DBits'(ay);
      sx1_q <= DBits'(bx) - DBits'(ax); sy1_q <= DBits'(by) - DBits'(ay);
      ax1_q <= ax; ay1_q <= ay;
    end
  end

  // Stage 2: the six products.
  logic v2_q;
  logic signed [ProdBits-1:0] p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
  logic signed [DBits-1:0] sx2_q, sy2_q;
  coord_t ax2_q, ay2_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_q <= adx_q * bdy_q; p1_q <= ady_q * bdx_q;
      p2_q <= acx_q * bcy_q; p3_q <= acy_q * bcx_q;
      p4_q <= cax_q * day_q; p5_q <= cay_q * dax_q;
      sx2_q <= sx1_q; sy2_q <= sy1_q; ax2_q <= ax1_q; ay2_q <= ay1_q;
    end
  end

  // Stage 3: the areas abd, abc, cda.
  logic v3_q;
  area_t abd_q, abc_q, cda_q;
  logic signed [DBits-1:0] sx3_q, sy3_q;
  coord_t ax3_q, ay3_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      abd_q <= AreaBits'(p0_q) - AreaBits'(p1_q);
      abc_q <= AreaBits'(p2_q) - AreaBits'(p3_q);
      cda_q <= AreaBits'(p4_q) - AreaBits'(p5_q);
      sx3_q <= sx2_q; sy3_q <= sy2_q; ax3_q <= ax2_q; ay3_q <= ay2_q;
    end
  end

  // Stage 4: cdb, first sign test.
  logic v4_q, h4_q;
  area_t cda4_q, cdb4_q;
  logic signed [DBits-1:0] sx4_q, sy4_q;
  coord_t ax4_q, ay4_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      cda4_q <= cda_q;
      cdb4_q <= cda_q + abc_q - abd_q;
      h4_q   <= (abd_q != '0) && (abc_q != '0) &&
                (abd_q[AreaBits-1] != abc_q[AreaBits-1]);
      sx4_q <= sx3_q; sy4_q <= sy3_q; ax4_q <= ax3_q; ay4_q <= ay3_q;
    end
  end

  // Stage 5: second sign test, magnitudes and divider seed.
  logic v5_q;
  sgi_cell_t seed_q;
  logic [MagBits-1:0] mag_n, mag_m;
  assign mag_n = cda4_q[AreaBits-1] ? MagBits'(-cda4_q) : MagBits'(cda4_q);
  assign mag_m = cdb4_q[AreaBits-1] ? MagBits'(-cdb4_q) : MagBits'(cdb4_q);
  always_ff @(posedge clk_i) begin
    if (en) begin
      seed_q.hit <= h4_q && (cda4_q != '0) && (cdb4_q != '0) &&
                    (cda4_q[AreaBits-1] != cdb4_q[AreaBits-1]);
      // n < den, so n*2 starts the remainder for the first fraction bit.
      seed_q.rem <= {RemBits'(mag_n)} << 1;
      seed_q.den <= DenBits'(mag_n) + DenBits'(mag_m);
      seed_q.quo <= '0;
      seed_q.a_x <= ax4_q; seed_q.a_y <= ay4_q;
      seed_q.span_x <= sx4_q; seed_q.span_y <= sy4_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q} <= '0;
    end else if (en) begin
      {v1_q, v2_q, v3_q, v4_q, v5_q} <= {s_axis_tvalid, v1_q, v2_q, v3_q, v4_q};
    end
  end

  // Row of division cells, one quotient bit each.
  logic      cv   [NCell+1];
  sgi_cell_t cdat [NCell+1];
  assign cv[0]   = v5_q;
  assign cdat[0] = seed_q;
  for (genvar g = 0; g < NCell; g++) begin : g_cell
    sgi_div_cell u_cell (
      .clk_i, .rst_ni, .en_i(en),
      .vld_i(cv[g]), .cell_i(cdat[g]),
      .vld_o(cv[g+1]), .cell_o(cdat[g+1])
    );
  end

  sgi_cell_t fin;
  logic [TFracBits-1:0] frac;
  assign fin  = cdat[NCell];
  assign frac = fin.hit ? fin.quo : '0;

  // Stage A: span times t, as magnitude products.
  localparam int unsigned MBits = DBits + TFracBits;
  logic va_q, ha_q, nx_q, ny_q;
  logic [MBits-1:0] mx_q, my_q;
  logic [TFracBits-1:0] ta_q;
  coord_t axa_q, aya_q;
  logic [DBits-1:0] spx_mag, spy_mag;
  assign spx_mag = fin.span_x[DBits-1] ? DBits'(-fin.span_x) : DBits'(fin.span_x);
  assign spy_mag = fin.span_y[DBits-1] ? DBits'(-fin.span_y) : DBits'(fin.span_y);
  always_ff @(posedge clk_i) begin
    if (en) begin
      mx_q <= MBits'(spx_mag) * MBits'(frac);
      my_q <= MBits'(spy_mag) * MBits'(frac);
      nx_q <= fin.span_x[DBits-1]; ny_q <= fin.span_y[DBits-1];
      ha_q <= fin.hit; ta_q <= frac; axa_q <= fin.a_x; aya_q <= fin.a_y;
    end
  end

  // Stage B: floor of the signed offset, added to A.
  logic [MBits-1:0] qx, qy;
  assign qx = (mx_q >> TFracBits) + MBits'(nx_q && (mx_q[TFracBits-1:0] != '0));
  assign qy = (my_q >> TFracBits) + MBits'(ny_q && (my_q[TFracBits-1:0] != '0));
  logic vb_q, hb_q;
  logic [TFracBits-1:0] tb_q;
  coord_t pxb_q, pyb_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      hb_q  <= ha_q; tb_q <= ta_q;
      pxb_q <= nx_q ? axa_q - CoordBits'(qx) : axa_q + CoordBits'(qx);
      pyb_q <= ny_q ? aya_q - CoordBits'(qy) : aya_q + CoordBits'(qy);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0; vb_q <= 1'b0;
    end else if (en) begin
      va_q <= cv[NCell]; vb_q <= va_q;
    end
  end

  assign m_axis_tvalid = vb_q;
  assign m_axis_tdata  = OutBits'({pyb_q, pxb_q, tb_q, hb_q});

`ifndef ASSERT_OFF
  // A miss always reports zero t.
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !hb_q |-> tb_q == '0) else $error("miss with nonzero t");
  // A stalled pipeline keeps its output beat.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed while stalled");
  // Ready follows the output stage alone.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready) else $error("input blocked with empty output");
`endif

endmodule

[dv/segment_intersect_2d_checker.sv]
// Scoreboard for the 2D segment intersection block: watches both stream channels,
// predicts each result from the accepted input beat and compares field by field.
// Depends on sgi_pkg.
module segment_intersect_2d_checker
  import sgi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [InBits-1:0]  s_axis_tdata,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [OutBits-1:0] m_axis_tdata,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic                 hit;
    logic [TFracBits-1:0] param_t;
    coord_t               point_x;
    coord_t               point_y;
  } crossing_t;

  crossing_t crossing_q[$];
  int        fail_count;

  assign fail_count_o = fail_count;
  assign pending_o    = crossing_q.size();

  // Doubled signed area of triangle PQR, exact in 64 bits.
  function automatic longint tri_area(longint px, longint py, longint qx, longint qy,
                                      longint rx, longint ry);
    return (px - rx) * (qy - ry) - (py - ry) * (qx - rx);
  endfunction

  // Start plus floor(frac * span / 2^TFracBits).
  function automatic coord_t lerp(longint start, longint span, longint frac);
    longint prod;
    prod = span * frac;
    return coord_t'(start + (prod >>> TFracBits));
  endfunction

  function automatic crossing_t predict_crossing(logic [InBits-1:0] beat);
    coord_t    c[8];
    longint    ax, ay, bx, by, cx, cy, dx, dy;
    longint    abd, abc, cda, cdb, mag, den;
    crossing_t r;
    for (int i = 0; i < 8; i++) c[i] = beat[i*CoordBits +: CoordBits];
    ax = c[0]; ay = c[1]; bx = c[2]; by = c[3];
    cx = c[4]; cy = c[5]; dx = c[6]; dy = c[7];
    r.hit = 1'b0;
    r.param_t = '0;
    r.point_x = c[0];
    r.point_y = c[1];
    abd = tri_area(ax, ay, bx, by, dx, dy);
    abc = tri_area(ax, ay, bx, by, cx, cy);
    if (abd != 0 && abc != 0 && ((abd < 0) != (abc < 0))) begin
      cda = tri_area(cx, cy, dx, dy, ax, ay);
      cdb = cda + abc - abd;
      if (cda != 0 && cdb != 0 && ((cda < 0) != (cdb < 0))) begin
        mag = cda < 0 ? -cda : cda;
        den = mag + (cdb < 0 ? -cdb : cdb);
        // Magnitudes stay below 2^35, so the shifted numerator fits in 64 bits.
        r.param_t = TFracBits'((mag <<< TFracBits) / den);
        r.point_x = lerp(ax, bx - ax, longint'(r.param_t));
        r.point_y = lerp(ay, by - ay, longint'(r.param_t));
        r.hit = 1'b1;
      end
    end
    return r;
  endfunction

  // Predict on input beats, compare on output beats.
  always @(posedge clk_i or negedge rst_ni) begin
    crossing_t want, got;
    if (!rst_ni) begin
      fail_count <= 0;
      crossing_q.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) crossing_q.push_back(predict_crossing(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        got.hit     = m_axis_tdata[0];
        got.param_t = m_axis_tdata[1 +: TFracBits];
        got.point_x = m_axis_tdata[1+TFracBits +: CoordBits];
        got.point_y = m_axis_tdata[1+TFracBits+CoordBits +: CoordBits];
        if (crossing_q.size() == 0) begin
          $error("unexpected output beat %h", m_axis_tdata);
          fail_count <= fail_count + 1;
        end else begin
          want = crossing_q.pop_front();
          if (got.hit !== want.hit)
            $error("hit: expected %0d, actual %0d", want.hit, got.hit);
          if (got.param_t !== want.param_t)
            $error("param_t: expected %0d, actual %0d", want.param_t, got.param_t);
          if (got.point_x !== want.point_x)
            $error("point_x: expected %0d, actual %0d", want.point_x, got.point_x);
          if (got.point_y !== want.point_y)
            $error("point_y: expected %0d, actual %0d", want.point_y, got.point_y);
          if (got !== want) fail_count <= fail_count + 1;
        end
      end
    end
  end

endmodule

[dv/testbench.sv]
// Stimulus and verdict for the 2D segment intersection block: directed corner
// cases, then random crossing and non-crossing segment pairs under backpressure.
// Depends on sgi_pkg, segment_intersect_2d and segment_intersect_2d_checker.
module testbench;
  import sgi_pkg::*;

  localparam int NumRandom   = 500;
  localparam int LatencyWait = 40;
  localparam int IdleLimit   = 2000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [InBits-1:0]  s_axis_tdata = '0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [OutBits-1:0] m_axis_tdata;
  int                 fail_count;
  int                 pending;
  bit                 calm = 1'b0;
  bit                 hold_off = 1'b0;
  int                 idle_cycles = 0;

  always #10 clk_i = ~clk_i;

  segment_intersect_2d uut (.*);

  segment_intersect_2d_checker checker_i (.*, .fail_count_o(fail_count),
                                          .pending_o(pending));

  // Send one segment pair, with an occasional burst of idle cycles first.
  task automatic send_pair(coord_t ax, ay, bx, by, cx, cy, dx, dy);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dy, dx, cy, cx, by, bx, ay, ax};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  function automatic coord_t rnd_coord(int span);
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom);
      default: return coord_t'($signed($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  // Receiver: random stall bursts, plus a long hold-off when asked.
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off) m_axis_tready <= 1'b0;
      else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else m_axis_tready <= 1'b1;
    end
  end

  initial begin
    @(posedge rst_ni);
    repeat (60) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (200) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Watchdog on cycles without any accepted beat.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("[segment_intersect_2d] ERROR");
      $finish;
    end
  end

  initial begin
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
    int     span;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: plain crossing, collinear, touching, degenerate, parallel, extremes.
    send_pair(-256, 0, 256, 0, 0, -256, 0, 256);
    send_pair(0, 0, 512, 0, 128, 0, 768, 0);
    send_pair(0, 0, 512, 0, 256, 0, 256, 256);
    send_pair(100, 100, 100, 100, 0, 0, 200, 200);
    send_pair(0, 0, 512, 0, 0, 10, 512, 10);
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_pair(32767, 32767, -32768, -32768, 32767, -32768, -32768, 32767);
    send_pair(-32768, 0, 32767, 0, 0, -32768, 1, 32767);
    send_pair(0, -32768, 0, 32767, -32768, 1, 32767, 0);
    send_pair(-1, -1, 1, 1, -1, 1, 1, -1);
    send_pair(0, 0, 3, 1, 1, 0, 2, 5);
    send_pair(0, 0, 1000, 1, 999, -5, 999, 5);
    send_pair(1000, 1, 0, 0, 1, -5, 1, 5);
    send_pair(-1, 0, -1, 0, -1, 0, -1, 0);
    send_pair(32767, -32768, -32768, 32767, 0, 0, 32767, 32767);

    // Random: mostly crossing pairs built around a shared point, rest unconstrained.
    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom - 60) calm = 1'b1;
      span = $urandom_range(0, 1) ? 32767 : $urandom_range(1, 600);
      ax = rnd_coord(span); ay = rnd_coord(span);
      bx = rnd_coord(span); by = rnd_coord(span);
      if ($urandom_range(0, 2) != 0) begin
        // Pick C and D on opposite sides of the midpoint of AB.
        cx = coord_t'((longint'(ax) + bx) / 2 + $signed($urandom_range(0, 4000)) - 2000);
        cy = coord_t'((longint'(ay) + by) / 2 + $signed($urandom_range(0, 4000)) - 2000);
        dx = coord_t'(2 * ((longint'(ax) + bx) / 2) - cx);
        dy = coord_t'(2 * ((longint'(ay) + by) / 2) - cy);
      end else begin
        cx = rnd_coord(span); cy = rnd_coord(span);
        dx = rnd_coord(span); dy = rnd_coord(span);
      end
      send_pair(ax, ay, bx, by, cx, cy, dx, dy);
    end
    s_axis_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (LatencyWait) @(posedge clk_i);
    if (fail_count == 0) $display("[segment_intersect_2d] OK");
    else $display("[segment_intersect_2d] ERROR");
    $finish;
  end

endmodule

[filelist.f]
rtl/sgi_pkg.sv
rtl/sgi_div_cell.sv
rtl/segment_intersect_2d.sv
dv/segment_intersect_2d_checker.sv
dv/testbench.sv
